### src/gce_pkg.sv
// shared types and constants for the gaussian cdf evaluator
package gce_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned OutW = FracBits + 1;
  localparam logic [OutW-1:0] OutOne = OutW'(1) << FracBits;

  // config register indexes
  localparam logic CfgMean = 1'b0;
  localparam logic CfgSigma = 1'b1;

  localparam logic [30:0] SigmaReset = 31'(1) << FracBits;

  localparam logic [30:0] Q30One = 31'h4000_0000;
  localparam logic [29:0] Q30Half = 30'h2000_0000;

  localparam logic [31:0] InvSqrt2 = 32'd3037000500;
  localparam logic [28:0] CoefP = 29'd351748265;
  localparam logic [29:0] Ln2 = 30'd744261118;

  localparam logic signed [34:0] CoefA [1:5] = '{
    35'sd273621191, -35'sd305476044, 35'sd1526231383,
    -35'sd1560310108, 35'sd1139675401
  };

  // floor(2^34 / i) for the exp series divisors
  localparam logic [34:0] Recip [1:10] = '{
    35'd17179869184, 35'd8589934592, 35'd5726623061, 35'd4294967296,
    35'd3435973836, 35'd2863311530, 35'd2454267026, 35'd2147483648,
    35'd1908874353, 35'd1717986918
  };

  // classified sample from front to back
  typedef struct packed {
    logic        neg;
    logic        far;
    logic        last;
    logic [32:0] a;
  } gce_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } gce_qstat_t;

endpackage

### src/gaussian_cdf_eval.sv
// Gaussian cdf evaluator top level: config registers, front end, queue and back end.
// Takes one sample per cycle while the queue has room and returns one probability
// word per sample, in order. The front register passes the word to the queue, the
// back end pops it into the first of its 109 stages, and the output register follows
// the last stage. The two long dividers (one quotient bit per stage, 31 stages each)
// and the 30-stage exp series set the depth. A four-word queue sits between front and
// back so the input side keeps taking samples until the queue is full while the
// output is stalled. The user is to write dist_mean and dist_sigma through the config
// port only while no samples are in flight; the block itself does not enforce it.
// Results use the values held at that time.
module gaussian_cdf_eval (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] sample_value
  input  logic        s_axis_tlast,   // last_sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [16:0] cum_prob
  output logic        m_axis_tlast,   // last_result
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] mean_q;
  logic [30:0] sigma_q;
  logic push, pop;
  gce_pkg::gce_item_t  f_item, q_item;
  gce_pkg::gce_qstat_t qstat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q  <= '0;
      sigma_q <= gce_pkg::SigmaReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        gce_pkg::CfgMean:  mean_q  <= cfg_data_i;
        gce_pkg::CfgSigma: sigma_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  gce_front u_front (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .mean_i(mean_q), .sigma_i(sigma_q),
    .qstat_i(qstat), .push_o(push), .item_o(f_item)
  );

  gce_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .item_i(f_item), .pop_i(pop),
    .item_o(q_item), .stat_o(qstat)
  );

  gce_back u_back (
    .clk_i, .rst_ni,
    .item_i(q_item), .qstat_i(qstat), .pop_o(pop), .sigma_i(sigma_q),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  a_prob_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[16:0] <= gce_pkg::OutOne)
    else $error("probability above one");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty)
    else $error("queue popped while empty");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> qstat.full && !push)
    else $error("input stalled with room in the queue");

endmodule

### src/gce_front.sv
// front end: takes samples, forms the deviation and flags the far tails
module gce_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [31:0]        s_axis_tdata,   // [31:0] sample_value
  input  logic               s_axis_tlast,
  input  logic [31:0]        mean_i,
  input  logic [30:0]        sigma_i,
  input  gce_pkg::gce_qstat_t qstat_i,
  output logic               push_o,
  output gce_pkg::gce_item_t item_o
);

  logic               vld_q, vld_d;
  gce_pkg::gce_item_t item_q, item_d;
  logic signed [32:0] dev;
  logic [30:0]        sig_eff;
  logic [33:0]        six_sig;

  assign push_o        = vld_q && !qstat_i.full;
  assign s_axis_tready = !vld_q || !qstat_i.full;
  assign item_o        = item_q;

  always_comb begin
    sig_eff = (sigma_i == '0) ? 31'd1 : sigma_i;
    six_sig = ({3'b0, sig_eff} << 2) + ({3'b0, sig_eff} << 1);
    dev = $signed({s_axis_tdata[31], s_axis_tdata}) - $signed({mean_i[31], mean_i});
    item_d.neg  = dev[32];
    item_d.a    = dev[32] ? 33'(-dev) : 33'(dev);
    item_d.far  = {1'b0, item_d.a} >= six_sig;
    item_d.last = s_axis_tlast;
    vld_d = vld_q;
    if (push_o) vld_d = 1'b0;
    if (s_axis_tvalid && s_axis_tready) vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q <= item_d;
    end
  end

endmodule

### src/gce_fifo.sv
// four-entry queue between front and back end
module gce_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  gce_pkg::gce_item_t  item_i,
  input  logic                pop_i,
  output gce_pkg::gce_item_t  item_o,
  output gce_pkg::gce_qstat_t stat_o
);

  gce_pkg::gce_item_t mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q, cnt_d;

  assign item_o       = mem_q[rd_q];
  assign stat_o.full  = cnt_q == 3'd4;
  assign stat_o.empty = cnt_q == 3'd0;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 3'd1;
    if (!push_i && pop_i) cnt_d = cnt_q - 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 2'd1;
      if (pop_i) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

### src/gce_back.sv
// back end: pipelined divides, erf polynomial, exp series and output register
module gce_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gce_pkg::gce_item_t  item_i,
  input  gce_pkg::gce_qstat_t qstat_i,
  output logic                pop_o,
  input  logic [30:0]         sigma_i,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata,  // [16:0] cum_prob
  output logic                m_axis_tlast
);

  localparam int unsigned NSt = 109;

  typedef struct packed {
    logic               neg;
    logic               far;
    logic               last;
    logic [32:0]        a;
    logic [33:0]        rem;
    logic [30:0]        quo;
    logic [31:0]        den;
    logic [32:0]        z;
    logic [30:0]        t;
    logic signed [34:0] acc;
    logic [36:0]        w;
    logic [5:0]         k;
    logic [30:0]        e;
    logic [30:0]        x;
    logic [65:0]        yr;
    logic [33:0]        qv;
  } gce_work_t;

  gce_work_t st_q [NSt];
  gce_work_t st_d [NSt];
  logic [NSt-1:0] vld_q;
  logic       adv;
  logic [30:0] sig_eff;
  logic       out_vld_q;
  logic [gce_pkg::OutW-1:0] prob_q, prob_d;
  logic       last_q;

  function automatic logic signed [34:0] mulq(logic signed [34:0] a, logic [30:0] t);
    logic [34:0] m;
    logic [65:0] p;
    logic [34:0] r;
    m = a[34] ? 35'(-a) : 35'(a);
    p = (66'(m) * 66'(t) + 66'(gce_pkg::Q30Half)) >> 30;
    r = p[34:0];
    return a[34] ? $signed(35'd0 - r) : $signed(r);
  endfunction

  // one quotient bit of a*2^28 / sigma
  function automatic gce_work_t div_r(gce_work_t s, int unsigned b, logic [30:0] sig);
    gce_work_t o;
    logic nb;
    logic [31:0] rem2;
    o = s;
    nb = 1'b0;
    if (b >= 28) nb = s.a[6'(b - 28)];
    rem2 = {s.rem[30:0], nb};
    if (rem2 >= {1'b0, sig}) begin
      o.rem = 34'(rem2 - {1'b0, sig});
      o.quo[5'(b)] = 1'b1;
    end else begin
      o.rem = 34'(rem2);
    end
    return o;
  endfunction

  // one quotient bit of 2^60 / den
  function automatic gce_work_t div_t(gce_work_t s, int unsigned b);
    gce_work_t o;
    logic [32:0] rem2;
    o = s;
    rem2 = {s.rem[31:0], 1'b0};
    if (rem2 >= {1'b0, s.den}) begin
      o.rem = 34'(rem2 - {1'b0, s.den});
      o.quo[5'(b)] = 1'b1;
    end else begin
      o.rem = 34'(rem2);
    end
    return o;
  endfunction

  // exp series step for divisor i, phase ph
  function automatic gce_work_t exp_step(gce_work_t s, int unsigned i, int unsigned ph);
    gce_work_t o;
    logic [61:0] pf;
    logic [30:0] q0, q;
    logic [34:0] rr;
    o = s;
    pf = '0;
    q0 = '0;
    q  = '0;
    rr = '0;
    case (ph)
      0: begin
        pf = 62'(s.w[29:0]) * 62'(s.e);
        o.x = 31'((pf + 62'(gce_pkg::Q30Half)) >> 30);
      end
      1: begin
        o.yr = 66'(s.x) * 66'(gce_pkg::Recip[i]);
      end
      default: begin
        q0 = 31'(s.yr >> 34);
        rr = 35'(s.x) - 35'(q0) * 35'(i);
        q = (rr >= 35'(i)) ? q0 + 31'd1 : q0;
        o.e = (q > gce_pkg::Q30One) ? 31'd0 : gce_pkg::Q30One - q;
      end
    endcase
    return o;
  endfunction

  assign adv     = !out_vld_q || m_axis_tready;
  assign pop_o   = adv && !qstat_i.empty;
  assign sig_eff = (sigma_i == '0) ? 31'd1 : sigma_i;

  always_comb begin
    logic [63:0] pz;
    logic [61:0] sq;
    logic [65:0] pq;
    logic [36:0] lim;
    // entry
    st_d[0]      = '0;
    st_d[0].neg  = item_i.neg;
    st_d[0].far  = item_i.far;
    st_d[0].last = item_i.last;
    st_d[0].a    = item_i.a;
    st_d[0].rem  = 34'(item_i.a >> 3);
    for (int unsigned j = 1; j <= 31; j++) begin
      st_d[j] = div_r(st_q[j-1], 31 - j, sig_eff);
    end
    // z = r / sqrt2 in q30
    st_d[32] = st_q[31];
    pz = 64'(st_q[31].quo) * 64'(gce_pkg::InvSqrt2);
    st_d[32].z = 33'((pz + 64'(gce_pkg::Q30Half)) >> 30);
    // divisor 1 + p*z, remainder seeded with the top of 2^60
    st_d[33] = st_q[32];
    pz = 64'(gce_pkg::CoefP) * 64'(st_q[32].z);
    st_d[33].den = 32'(64'(gce_pkg::Q30One) + ((pz + 64'(gce_pkg::Q30Half)) >> 30));
    st_d[33].rem = 34'(gce_pkg::Q30Half);
    st_d[33].quo = '0;
    for (int unsigned j = 34; j <= 64; j++) begin
      st_d[j] = div_t(st_q[j-1], 64 - j);
    end
    // horner polynomial
    st_d[65] = st_q[64];
    st_d[65].t = st_q[64].quo;
    st_d[65].acc = mulq(gce_pkg::CoefA[5], st_q[64].quo) + gce_pkg::CoefA[4];
    for (int unsigned j = 66; j <= 68; j++) begin
      st_d[j] = st_q[j-1];
      st_d[j].acc = mulq(st_q[j-1].acc, st_q[j-1].t) + gce_pkg::CoefA[69 - j];
    end
    st_d[69] = st_q[68];
    st_d[69].acc = mulq(st_q[68].acc, st_q[68].t);
    if (st_d[69].acc[34]) st_d[69].acc = '0;
    // w = z^2
    st_d[70] = st_q[69];
    sq = 62'(st_q[69].z[32:2]) * 62'(st_q[69].z[32:2]);
    st_d[70].w = 37'(sq >> 26);
    st_d[70].k = '0;
    st_d[70].e = gce_pkg::Q30One;
    // range reduction by ln2, one bit of k a stage
    for (int unsigned j = 71; j <= 76; j++) begin
      st_d[j] = st_q[j-1];
      lim = 37'(gce_pkg::Ln2) << (76 - j);
      if (st_q[j-1].w >= lim) begin
        st_d[j].w = st_q[j-1].w - lim;
        st_d[j].k[3'(76 - j)] = 1'b1;
      end
    end
    for (int unsigned m = 0; m < 10; m++) begin
      for (int unsigned ph = 0; ph < 3; ph++) begin
        st_d[77 + 3*m + ph] = exp_step(st_q[76 + 3*m + ph], 10 - m, ph);
      end
    end
    st_d[107] = st_q[106];
    st_d[107].e = st_q[106].e >> st_q[106].k;
    st_d[108] = st_q[107];
    pq = 66'(st_q[107].acc[33:0]) * 66'(st_q[107].e);
    st_d[108].qv = 34'((pq + 66'(gce_pkg::Q30Half)) >> 30);
  end

  // final combine and rounding
  always_comb begin
    logic [30:0] qc, yv;
    logic [31:0] v;
    logic [32:0] res;
    qc = (st_q[108].qv > 34'(gce_pkg::Q30One)) ? gce_pkg::Q30One : st_q[108].qv[30:0];
    yv = gce_pkg::Q30One - qc;
    v = st_q[108].neg ? 32'(gce_pkg::Q30One - yv) : 32'(gce_pkg::Q30One) + 32'(yv);
    res = (33'(v) + (33'(1) << (30 - gce_pkg::FracBits))) >> (31 - gce_pkg::FracBits);
    if (res > 33'(gce_pkg::OutOne)) res = 33'(gce_pkg::OutOne);
    prob_d = res[gce_pkg::OutW-1:0];
    if (st_q[108].far) prob_d = st_q[108].neg ? '0 : gce_pkg::OutOne;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[NSt-2:0], !qstat_i.empty};
      out_vld_q <= vld_q[NSt-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int unsigned j = 0; j < NSt; j++) begin
        st_q[j] <= st_d[j];
      end
      prob_q <= prob_d;
      last_q <= st_q[108].last;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(24 - gce_pkg::OutW)'(0), prob_q};
  assign m_axis_tlast  = last_q;

endmodule

### tb/gaussian_cdf_eval_test.sv
// self-checking testbench for the gaussian cdf evaluator
module gaussian_cdf_eval_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
  } sample_t;

  typedef struct packed {
    logic [gce_pkg::OutW-1:0] prob;
    logic                     last;
  } prob_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = gce_pkg::CfgMean;
  logic [31:0] cfg_data_i = '0;

  gaussian_cdf_eval dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  sample_t     pending_samples[$];
  prob_t       expected_probs[$];
  logic [31:0] mean_reg = '0;
  logic [30:0] sigma_reg = gce_pkg::SigmaReset;
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_cycles = 0;
  int          quiet_cycles = 0;
  logic        in_fire = 1'b0;

  localparam longint unsigned One = 64'd1 << 30;
  localparam longint unsigned Half = 64'd1 << 29;

  function automatic longint signed round_mul(longint signed x, longint unsigned t);
    longint unsigned m;
    longint unsigned p;
    m = (x < 0) ? longint'(-x) : longint'(x);
    p = (m * t + Half) >> 30;
    return (x < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint unsigned exp_neg(longint unsigned w);
    longint unsigned k;
    longint unsigned f;
    longint unsigned e;
    longint unsigned term;
    k = w / gce_pkg::Ln2;
    f = w - k * gce_pkg::Ln2;
    e = One;
    for (int i = 10; i >= 1; i--) begin
      term = ((f * e + Half) >> 30) / i;
      e = (term > One) ? 0 : One - term;
    end
    if (k > 62) return 0;
    return e >> k;
  endfunction

  function automatic logic [gce_pkg::OutW-1:0] cdf_predict(logic [31:0] x,
                                                           logic [31:0] mu,
                                                           logic [30:0] sg);
    longint signed   d;
    longint unsigned s, a, r, z, t, z28, w, q, y, v, res, poly;
    longint signed   acc;
    logic            neg;
    s = (sg == 0) ? 1 : longint'(sg);
    d = longint'($signed(x)) - longint'($signed(mu));
    neg = d < 0;
    a = neg ? longint'(-d) : longint'(d);
    if (a >= 6 * s) return neg ? '0 : gce_pkg::OutOne;
    r = (a << 28) / s;
    z = (r * longint'(gce_pkg::InvSqrt2) + Half) >> 30;
    t = (64'd1 << 60) / (One + ((longint'(gce_pkg::CoefP) * z + Half) >> 30));
    acc = 1139675401;
    acc = round_mul(acc, t) - 1560310108;
    acc = round_mul(acc, t) + 1526231383;
    acc = round_mul(acc, t) - 305476044;
    acc = round_mul(acc, t) + 273621191;
    acc = round_mul(acc, t);
    poly = (acc < 0) ? 0 : acc;
    z28 = z >> 2;
    w = (z28 * z28) >> 26;
    q = (poly * exp_neg(w) + Half) >> 30;
    if (q > One) q = One;
    y = One - q;
    v = neg ? One - y : One + y;
    res = (v + (64'd1 << (30 - gce_pkg::FracBits))) >> (31 - gce_pkg::FracBits);
    if (res > gce_pkg::OutOne) res = gce_pkg::OutOne;
    return res[gce_pkg::OutW-1:0];
  endfunction

  // input side: a word is presented at the falling edge and held until taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && !in_fire) begin
        // hold current word
      end else if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pending_samples[0].value;
        s_axis_tlast <= pending_samples[0].last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output side: random stalls, or a long hold counted down here
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        hold_cycles <= hold_cycles - 1;
      end else begin
        m_axis_tready <= $urandom_range(99) >= recv_stall_pct;
      end
    end
  end

  always @(posedge clk_i) begin
    in_fire <= s_axis_tvalid && s_axis_tready;
    if (s_axis_tvalid && s_axis_tready) begin
      expected_probs.push_back('{cdf_predict(s_axis_tdata, mean_reg, sigma_reg),
                                 s_axis_tlast});
      void'(pending_samples.pop_front());
    end
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_probs.size() == 0) begin
        $display("%0t: unexpected word prob=%0d last=%0b", $time,
                 m_axis_tdata[gce_pkg::OutW-1:0], m_axis_tlast);
        errors++;
      end else begin
        if (m_axis_tdata[gce_pkg::OutW-1:0] !== expected_probs[0].prob) begin
          $display("%0t: prob mismatch expected %0d actual %0d", $time,
                   expected_probs[0].prob, m_axis_tdata[gce_pkg::OutW-1:0]);
          errors++;
        end
        if (m_axis_tlast !== expected_probs[0].last) begin
          $display("%0t: last mismatch expected %0b actual %0b", $time,
                   expected_probs[0].last, m_axis_tlast);
          errors++;
        end
        void'(expected_probs.pop_front());
      end
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 5000) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == gce_pkg::CfgMean) mean_reg = data;
    else sigma_reg = data[30:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_samples.size() == 0 && expected_probs.size() == 0);
    repeat (150) @(posedge clk_i);
  endtask

  // mostly samples within a few sigma of the mean, some anywhere
  task automatic queue_random(int n);
    longint signed off;
    logic [31:0]   v;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 7) begin
        off = (longint'(sigma_reg) * ($signed($urandom_range(16000)) - 8000)) / 1000;
        if ($urandom_range(19) == 0) off = $signed($urandom_range(40)) - 20;
        v = 32'($signed(mean_reg) + off);
      end else begin
        v = $urandom;
      end
      pending_samples.push_back('{v, 1'($urandom_range(7) == 0)});
    end
  endtask

  initial begin
    logic [31:0] mean_set [6];
    logic [31:0] sigma_set [6];
    int          idle_mode [4][2];
    longint signed s;
    mean_set = '{32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'hfffd_0000, 32'h0, 32'h1234_5678};
    sigma_set = '{32'h1_0000, 32'h1, 32'h7fff_ffff, 32'h3_8000, 32'h7fff_ffff, 32'h9};
    idle_mode = '{'{0, 0}, '{75, 0}, '{0, 75}, '{28, 28}};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, zero deviation, both tails and the far-tail edge
    s = 6 * 65536;
    pending_samples.push_back('{32'h0, 1'b0});
    pending_samples.push_back('{32'h8000_0000, 1'b1});
    pending_samples.push_back('{32'h7fff_ffff, 1'b0});
    pending_samples.push_back('{32'hffff_ffff, 1'b1});
    pending_samples.push_back('{32'h1, 1'b0});
    pending_samples.push_back('{32'(s), 1'b0});
    pending_samples.push_back('{32'(s - 1), 1'b1});
    pending_samples.push_back('{32'(-s), 1'b0});
    pending_samples.push_back('{32'(-s + 1), 1'b0});
    pending_samples.push_back('{32'h1_0000, 1'b1});
    pending_samples.push_back('{32'hffff_0000, 1'b0});
    pending_samples.push_back('{32'h5555_5555, 1'b0});
    pending_samples.push_back('{32'haaaa_aaaa, 1'b1});
    drain();

    // fill the pipe against a stalled output until the input backs up
    hold_cycles = 400;
    queue_random(200);
    drain();

    for (int p = 0; p < 12; p++) begin
      write_reg(gce_pkg::CfgMean, mean_set[p % 6]);
      write_reg(gce_pkg::CfgSigma, sigma_set[p % 6]);
      send_idle_pct = idle_mode[p % 4][0];
      recv_stall_pct = idle_mode[p % 4][1];
      queue_random(75);
      drain();
    end

    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
